// ===== design/rlu_pkg.sv =====
// ---------------------------------------------------------------------------
// rlu_pkg: shared types and constants
// Field types, command and action codes, register indexes and the
// configuration bundle of the signal-strength lock/unlock debouncer.
// ---------------------------------------------------------------------------
package rlu_pkg;

  // Width of the consecutive-sample run counters.
  localparam int COUNT_WIDTH = 16;
  localparam int NEED_W      = 16;
  // Common width for comparing a run count against a required count.
  localparam int CMP_W       = (COUNT_WIDTH > NEED_W) ? COUNT_WIDTH : NEED_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [1:0]              cmd_t;
  typedef logic signed [11:0]      rssi_t;
  typedef logic [31:0]             ms_t;
  typedef logic [1:0]              action_t;
  typedef logic [COUNT_WIDTH-1:0]  run_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

  localparam cmd_t CMD_SAMPLE = 2'd0;
  localparam cmd_t CMD_MANUAL = 2'd1;
  localparam cmd_t CMD_CLEAR  = 2'd2;

  localparam action_t ACT_NONE   = 2'd0;
  localparam action_t ACT_UNLOCK = 2'd1;
  localparam action_t ACT_LOCK   = 2'd2;

  localparam cfg_idx_t REG_UNLOCK_THR  = 3'd0;
  localparam cfg_idx_t REG_LOCK_THR    = 3'd1;
  localparam cfg_idx_t REG_HYST        = 3'd2;
  localparam cfg_idx_t REG_UNLOCK_NEED = 3'd3;
  localparam cfg_idx_t REG_LOCK_NEED   = 3'd4;
  localparam cfg_idx_t REG_COOLDOWN    = 3'd5;

  localparam run_t RUN_MAX = '1;

  typedef struct packed {
    logic signed [7:0] unlock_threshold;
    logic signed [7:0] lock_threshold;
    logic [6:0]        hysteresis_db;
    logic [15:0]       unlock_count_needed;
    logic [15:0]       lock_count_needed;
    logic [15:0]       cooldown_ms;
  } cfg_t;

  typedef struct packed {
    cmd_t  cmd;
    rssi_t rssi;
    logic  rssi_valid;
    ms_t   now_ms;
  } item_t;

  typedef struct packed {
    logic    lock_state;
    action_t action;
    logic    in_cooldown;
  } result_t;

endpackage

// ===== design/rlu_if.sv =====
// ---------------------------------------------------------------------------
// rlu_if: request channels
// Valid/ready channels for incoming sample requests and outgoing results.
// ---------------------------------------------------------------------------
interface rlu_in_if;
  logic           valid;
  logic           ready;
  rlu_pkg::cmd_t  cmd;
  rlu_pkg::rssi_t rssi;
  logic           rssi_valid;
  rlu_pkg::ms_t   now_ms;

  modport source (output valid, cmd, rssi, rssi_valid, now_ms, input ready);
  modport sink   (input valid, cmd, rssi, rssi_valid, now_ms, output ready);
endinterface

interface rlu_out_if;
  logic              valid;
  logic              ready;
  logic              lock_state;
  rlu_pkg::action_t  action;
  logic              in_cooldown;

  modport source (output valid, lock_state, action, in_cooldown, input ready);
  modport sink   (input valid, lock_state, action, in_cooldown, output ready);
endinterface

// ===== design/rlu_cfg.sv =====
// ---------------------------------------------------------------------------
// rlu_cfg: configuration registers
// Write-only register file holding thresholds, counts and cooldown length.
// ---------------------------------------------------------------------------
module rlu_cfg import rlu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_idx,
  input  cfg_data_t cfg_data,
  output cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unlock_threshold    <= -8'sd60;
      cfg.lock_threshold      <= -8'sd75;
      cfg.hysteresis_db       <= 7'd5;
      cfg.unlock_count_needed <= 16'd3;
      cfg.lock_count_needed   <= 16'd3;
      cfg.cooldown_ms         <= 16'd3000;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_UNLOCK_THR:  cfg.unlock_threshold    <= $signed(cfg_data[7:0]);
        REG_LOCK_THR:    cfg.lock_threshold      <= $signed(cfg_data[7:0]);
        REG_HYST:        cfg.hysteresis_db       <= cfg_data[6:0];
        REG_UNLOCK_NEED: cfg.unlock_count_needed <= cfg_data;
        REG_LOCK_NEED:   cfg.lock_count_needed   <= cfg_data;
        REG_COOLDOWN:    cfg.cooldown_ms         <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/rlu_eval.sv =====
// ---------------------------------------------------------------------------
// rlu_eval: debounce state and decision logic
// Holds lock state, run counters and cooldown, and decides each request.
// ---------------------------------------------------------------------------
module rlu_eval import rlu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic unlocked, unlocked_next;
  run_t unlock_run, unlock_run_next;
  run_t lock_run, lock_run_next;
  logic cd_active, cd_active_next;
  ms_t  cd_start, cd_start_next;

  logic signed [11:0] unlock_level;
  logic signed [8:0]  eff_lock;
  logic signed [12:0] lock_level;
  ms_t                elapsed;

  assign unlock_level = {cfg.unlock_threshold, 4'b0000};
  assign eff_lock     = 9'(cfg.lock_threshold) - $signed({2'b00, cfg.hysteresis_db});
  assign lock_level   = {eff_lock, 4'b0000};
  assign elapsed      = item.now_ms - cd_start;

  always_comb begin
    logic go;
    run_t bumped;
    unlocked_next   = unlocked;
    unlock_run_next = unlock_run;
    lock_run_next   = lock_run;
    cd_active_next  = cd_active;
    cd_start_next   = cd_start;
    res.action      = ACT_NONE;
    go              = 1'b0;
    bumped          = '0;
    case (item.cmd)
      CMD_MANUAL: begin
        cd_active_next = 1'b1;
        cd_start_next  = item.now_ms;
      end
      CMD_CLEAR: begin
        unlock_run_next = '0;
        lock_run_next   = '0;
      end
      CMD_SAMPLE: begin
        if (item.rssi_valid) begin
          go = 1'b1;
          if (cd_active) begin
            if (elapsed >= {16'd0, cfg.cooldown_ms}) begin
              cd_active_next = 1'b0;
            end else begin
              go = 1'b0;
            end
          end
        end
        if (go && !unlocked) begin
          if (item.rssi >= unlock_level) begin
            bumped          = (unlock_run == RUN_MAX) ? RUN_MAX : unlock_run + run_t'(1);
            unlock_run_next = bumped;
            lock_run_next   = '0;
            if (CMP_W'(bumped) >= CMP_W'(cfg.unlock_count_needed)) begin
              unlocked_next   = 1'b1;
              unlock_run_next = '0;
              res.action      = ACT_UNLOCK;
            end
          end else begin
            unlock_run_next = '0;
          end
        end else if (go) begin
          if (13'(item.rssi) <= lock_level) begin
            bumped          = (lock_run == RUN_MAX) ? RUN_MAX : lock_run + run_t'(1);
            lock_run_next   = bumped;
            unlock_run_next = '0;
            if (CMP_W'(bumped) >= CMP_W'(cfg.lock_count_needed)) begin
              unlocked_next = 1'b0;
              lock_run_next = '0;
              res.action    = ACT_LOCK;
            end
          end else begin
            lock_run_next = '0;
          end
        end
      end
      default: ;
    endcase
    res.lock_state  = unlocked_next;
    res.in_cooldown = cd_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unlocked   <= 1'b0;
      unlock_run <= '0;
      lock_run   <= '0;
      cd_active  <= 1'b0;
      cd_start   <= '0;
    end else if (fire) begin
      unlocked   <= unlocked_next;
      unlock_run <= unlock_run_next;
      lock_run   <= lock_run_next;
      cd_active  <= cd_active_next;
      cd_start   <= cd_start_next;
    end
  end

endmodule

// ===== design/rssi_lock_unlock_debouncer.sv =====
// ---------------------------------------------------------------------------
// rssi_lock_unlock_debouncer: hysteresis lock/unlock debouncer
// Counts consecutive qualifying signal-strength samples and fires lock or
// unlock actions, with a manual-command cooldown.
// ---------------------------------------------------------------------------
//
//   Channel   Dir  Payload                              Per request
//   samp      in   cmd, rssi, rssi_valid, now_ms        one sample or command
//   res       out  lock_state, action, in_cooldown      one result
//   cfg_*     in   cfg_idx, cfg_data (write only)       one register write
//
// A request is registered on acceptance, decided combinationally from the
// input register against the debounce state, and its result lands in the
// output register: one request per cycle sustained unless res stalls.
// The state update is made of compares and counter increments.
// rst is synchronous and returns the registers to their defaults and the
// state to locked with cleared counters and no cooldown.
// A stalled result holds in the output register while one more request
// waits in the input register; samp.ready drops only when both are full.
//
module rssi_lock_unlock_debouncer import rlu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rlu_in_if.sink    samp,
  rlu_out_if.source res,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_idx,
  input  cfg_data_t cfg_data
);

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_adv;
  result_t eval_res;
  result_t out_res;
  logic    out_valid;

  // The input register moves on whenever the output register is free or
  // is being emptied in this cycle.
  assign s1_adv     = s1_valid && (!out_valid || res.ready);
  assign samp.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samp.ready) begin
      s1_valid <= samp.valid;
    end
  end

  // Payload needs no reset; it is only used under s1_valid.
  always_ff @(posedge clk) begin
    if (samp.valid && samp.ready) begin
      s1_item <= '{cmd: samp.cmd, rssi: samp.rssi,
                   rssi_valid: samp.rssi_valid, now_ms: samp.now_ms};
    end
  end

  rlu_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // The debounce state commits exactly when the decided result is
  // captured into the output register.
  rlu_eval u_eval (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (s1_adv),
    .item (s1_item),
    .res  (eval_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= eval_res;
    end
  end

  assign res.valid       = out_valid;
  assign res.lock_state  = out_res.lock_state;
  assign res.action      = out_res.action;
  assign res.in_cooldown = out_res.in_cooldown;

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: testbench for rssi_lock_unlock_debouncer
// Sends sample, manual and clear requests through the valid/ready input
// channel and predicts every result with a cycle-free model of the debounce
// logic. Each result is checked field by field, in order. Directed requests
// cover the thresholds, hysteresis, cooldown wrap and register extremes.
// Random traffic follows, with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
module tb_top;
  import rlu_pkg::*;

  // Command code 3 has no meaning in the block and must be ignored.
  localparam cmd_t CMD_RESERVED     = 2'd3;
  // Ample drain slack for the block's input and output registers.
  localparam int   DRAIN_SLACK      = 6;
  localparam int   LONG_HOLD_CYCLES = 250;

  logic clk = 1'b0;
  logic rst;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_data;

  rlu_in_if  samp_if ();
  rlu_out_if res_if ();

  rssi_lock_unlock_debouncer dut (
    .clk      (clk),
    .rst      (rst),
    .samp     (samp_if),
    .res      (res_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL rssi_lock_unlock_debouncer");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Debounce predictor. It keeps its own copy of the registers and of the
  // lock state, both run counters and the cooldown. The reset values match
  // the block's register defaults.
  // -------------------------------------------------------------------------
  cfg_t  cur_cfg = '{unlock_threshold: -8'sd60, lock_threshold: -8'sd75,
                     hysteresis_db: 7'd5, unlock_count_needed: 16'd3,
                     lock_count_needed: 16'd3, cooldown_ms: 16'd3000};
  logic  dbn_unlocked   = 1'b0;
  run_t  dbn_unlock_run = '0;
  run_t  dbn_lock_run   = '0;
  logic  dbn_cd_active  = 1'b0;
  ms_t   dbn_cd_start   = '0;

  result_t predicted_results[$];
  int      mismatches = 0;

  // Flags shared between the test sequence and the channel processes.
  bit tx_steady     = 1'b0;  // sender offers requests back to back
  bit rx_steady     = 1'b0;  // receiver keeps ready high
  bit hold_request  = 1'b0;  // ask the receiver for one long hold-off
  bit hold_active   = 1'b0;  // receiver is in its long hold-off

  ms_t clock_ms = '0;        // free-running time used by the random traffic

  // Applies one accepted request to the predictor state and returns the
  // result that the block has to produce for it.
  function automatic result_t debounce_step(item_t it);
    result_t r;
    logic    go;
    ms_t     elapsed;
    int      level;
    int      unlock_level;
    int      lock_level;
    r.action = ACT_NONE;
    go = 1'b0;
    case (it.cmd)
      CMD_MANUAL: begin
        dbn_cd_active = 1'b1;
        dbn_cd_start  = it.now_ms;
      end
      CMD_CLEAR: begin
        dbn_unlock_run = '0;
        dbn_lock_run   = '0;
      end
      CMD_SAMPLE: begin
        // Invalid samples neither count nor end a cooldown.
        if (it.rssi_valid) begin
          go = 1'b1;
          if (dbn_cd_active) begin
            elapsed = it.now_ms - dbn_cd_start;
            if (elapsed >= ms_t'(cur_cfg.cooldown_ms)) begin
              dbn_cd_active = 1'b0;
            end else begin
              go = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    if (go) begin
      // Compare in Q8.4: thresholds are whole dB, so scale them by 16.
      level        = int'($signed(it.rssi));
      unlock_level = int'($signed(cur_cfg.unlock_threshold)) * 16;
      lock_level   = (int'($signed(cur_cfg.lock_threshold)) -
                      int'(cur_cfg.hysteresis_db)) * 16;
      if (!dbn_unlocked) begin
        if (level >= unlock_level) begin
          if (dbn_unlock_run != RUN_MAX) dbn_unlock_run = dbn_unlock_run + 1'b1;
          dbn_lock_run = '0;
          if (dbn_unlock_run >= cur_cfg.unlock_count_needed) begin
            dbn_unlocked   = 1'b1;
            dbn_unlock_run = '0;
            dbn_lock_run   = '0;
            r.action       = ACT_UNLOCK;
          end
        end else begin
          dbn_unlock_run = '0;
        end
      end else begin
        if (level <= lock_level) begin
          if (dbn_lock_run != RUN_MAX) dbn_lock_run = dbn_lock_run + 1'b1;
          dbn_unlock_run = '0;
          if (dbn_lock_run >= cur_cfg.lock_count_needed) begin
            dbn_unlocked   = 1'b0;
            dbn_unlock_run = '0;
            dbn_lock_run   = '0;
            r.action       = ACT_LOCK;
          end
        end else begin
          dbn_lock_run = '0;
        end
      end
    end
    r.lock_state  = dbn_unlocked;
    r.in_cooldown = dbn_cd_active;
    return r;
  endfunction

  function automatic cfg_t make_cfg(int ut, int lt, int hy, int un, int ln, int cd);
    cfg_t c;
    c.unlock_threshold    = 8'(ut);
    c.lock_threshold      = 8'(lt);
    c.hysteresis_db       = 7'(hy);
    c.unlock_count_needed = 16'(un);
    c.lock_count_needed   = 16'(ln);
    c.cooldown_ms         = 16'(cd);
    return c;
  endfunction

  // -------------------------------------------------------------------------
  // Channel and register helpers. Every task returns right after a rising
  // edge, and each one drives a given signal at most once per time step.
  // -------------------------------------------------------------------------

  // Offers one request after a random gap and waits until it is accepted.
  // valid stays high on return, so back-to-back requests never toggle it.
  task automatic send_request(cmd_t cmd, int rssi_val, logic vld, ms_t now);
    item_t it;
    int    gap;
    it.cmd        = cmd;
    it.rssi       = rssi_t'(rssi_val);
    it.rssi_valid = vld;
    it.now_ms     = now;
    if (tx_steady) begin
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      gap = $urandom_range(10, 40);
    end else if ($urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = 0;
    end
    if (gap > 0) begin
      samp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samp_if.valid      <= 1'b1;
    samp_if.cmd        <= it.cmd;
    samp_if.rssi       <= it.rssi;
    samp_if.rssi_valid <= it.rssi_valid;
    samp_if.now_ms     <= it.now_ms;
    @(posedge clk);
    while (!samp_if.ready) @(posedge clk);
    predicted_results.push_back(debounce_step(it));
  endtask

  // Withdraws the input request and waits until every predicted result has
  // come out, then lets the pipeline settle.
  task automatic wait_results_drained();
    samp_if.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Writes all six registers. Only called while the block is idle.
  task automatic program_config(cfg_t c);
    write_reg(REG_UNLOCK_THR,  {{8{c.unlock_threshold[7]}}, c.unlock_threshold});
    write_reg(REG_LOCK_THR,    {{8{c.lock_threshold[7]}}, c.lock_threshold});
    write_reg(REG_HYST,        {9'd0, c.hysteresis_db});
    write_reg(REG_UNLOCK_NEED, c.unlock_count_needed);
    write_reg(REG_LOCK_NEED,   c.lock_count_needed);
    write_reg(REG_COOLDOWN,    c.cooldown_ms);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_cfg = c;
  endtask

  // -------------------------------------------------------------------------
  // Result side: the receiver drives ready in its own process, and a checker
  // compares every accepted result with the oldest prediction.
  // -------------------------------------------------------------------------
  initial begin : result_receiver
    int span;
    forever begin
      if (hold_request) begin
        // Long hold-off: the block fills up and has to stall its input.
        hold_request = 1'b0;
        hold_active  = 1'b1;
        res_if.ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk);
        hold_active = 1'b0;
      end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        repeat (span) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        span = $urandom_range(1, 12);
        repeat (span) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: result with no request outstanding: lock_state %0b action %0d",
                 $time, res_if.lock_state, res_if.action);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        if (res_if.lock_state !== want.lock_state) begin
          $display("%0t: lock_state expected %0b actual %0b",
                   $time, want.lock_state, res_if.lock_state);
          mismatches++;
        end
        if (res_if.action !== want.action) begin
          $display("%0t: action expected %0d actual %0d",
                   $time, want.action, res_if.action);
          mismatches++;
        end
        if (res_if.in_cooldown !== want.in_cooldown) begin
          $display("%0t: in_cooldown expected %0b actual %0b",
                   $time, want.in_cooldown, res_if.in_cooldown);
          mismatches++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Default registers: unlock at -60 dBm (-960 in Q8.4), lock at -75 - 5 =
  // -80 dBm (-1280), three samples needed, 3000 ms cooldown.
  task automatic test_directed();
    // Ignored requests: an invalid sample and the unused command.
    send_request(CMD_SAMPLE, 2047, 1'b0, 32'h0000_0000);
    send_request(CMD_RESERVED, -2048, 1'b1, 32'hFFFF_FFFF);
    // One LSB below the unlock level does not count.
    send_request(CMD_SAMPLE, -961, 1'b1, 32'd10);
    // Two qualifying samples, then a clear restarts the run.
    send_request(CMD_SAMPLE, -960, 1'b1, 32'd20);
    send_request(CMD_SAMPLE, -960, 1'b1, 32'd30);
    send_request(CMD_CLEAR, 0, 1'b1, 32'd40);
    send_request(CMD_SAMPLE, -960, 1'b1, 32'd50);
    send_request(CMD_SAMPLE, 2047, 1'b1, 32'd60);
    send_request(CMD_SAMPLE, -960, 1'b1, 32'd70);   // unlock fires here
    // Now unlocked: one LSB above the lock level does not count.
    send_request(CMD_SAMPLE, -1279, 1'b1, 32'd80);
    send_request(CMD_SAMPLE, -1280, 1'b1, 32'd90);
    send_request(CMD_SAMPLE, -1280, 1'b1, 32'd100);
    send_request(CMD_SAMPLE, 2047, 1'b1, 32'd110);  // breaks the run
    send_request(CMD_SAMPLE, -2048, 1'b1, 32'd120);
    send_request(CMD_SAMPLE, -2048, 1'b1, 32'd130);
    send_request(CMD_SAMPLE, -2048, 1'b1, 32'd140); // lock fires here
    // Manual command just before the time wraps. The elapsed time is
    // computed modulo 2^32, so 2999 ms later is still inside the cooldown.
    send_request(CMD_MANUAL, 0, 1'b0, 32'hFFFF_FA00);
    send_request(CMD_SAMPLE, -960, 1'b1, 32'h0000_05B7);
    // An invalid sample never ends the cooldown, even after the time passed.
    send_request(CMD_SAMPLE, -960, 1'b0, 32'h0000_05B8);
    // Exactly 3000 ms: the cooldown ends and the sample counts.
    send_request(CMD_SAMPLE, -960, 1'b1, 32'h0000_05B8);
    send_request(CMD_CLEAR, 0, 1'b0, 32'h0000_05C0);
    // A second manual command at the top of the time range.
    send_request(CMD_MANUAL, 0, 1'b1, 32'hFFFF_FFFF);
    send_request(CMD_SAMPLE, -960, 1'b1, 32'h0000_0000);
    send_request(CMD_SAMPLE, -960, 1'b1, 32'h0000_0BB7);
  endtask

  // Register extremes: thresholds at both ends, no hysteresis and the largest
  // one, zero and largest counts needed, zero and largest cooldown.
  task automatic test_config_extremes();
    wait_results_drained();
    // Lowest unlock level and zero count needed: the first sample unlocks.
    // The lock level of -255 dBm is out of reach, so locking never happens.
    program_config(make_cfg(-128, -128, 127, 0, 0, 0));
    send_request(CMD_SAMPLE, -2048, 1'b1, 32'd1000);
    send_request(CMD_SAMPLE, -2048, 1'b1, 32'd1001);
    send_request(CMD_SAMPLE, -2048, 1'b1, 32'd1002);
    // Zero cooldown ends on the first valid sample, even with no time passed.
    send_request(CMD_MANUAL, 0, 1'b0, 32'd2000);
    send_request(CMD_SAMPLE, 2047, 1'b1, 32'd2000);

    wait_results_drained();
    // Top lock level with no hysteresis: 2032 locks, 2033 does not.
    program_config(make_cfg(127, 127, 0, 65535, 0, 65535));
    send_request(CMD_SAMPLE, 2033, 1'b1, 32'd3000);
    send_request(CMD_SAMPLE, 2032, 1'b1, 32'd3001);
    // Locked now, and 65535 samples would be needed to unlock.
    send_request(CMD_SAMPLE, 2047, 1'b1, 32'd3002);
    send_request(CMD_SAMPLE, 2047, 1'b1, 32'd3003);
    send_request(CMD_SAMPLE, 2031, 1'b1, 32'd3004);
    send_request(CMD_SAMPLE, 2032, 1'b1, 32'd3005);
    // Longest cooldown: 65534 ms is still inside, 65535 ends it.
    send_request(CMD_MANUAL, 0, 1'b1, 32'h1234_5678);
    send_request(CMD_SAMPLE, 2047, 1'b1, 32'h1235_5676);
    send_request(CMD_SAMPLE, 2047, 1'b1, 32'h1235_5677);

    wait_results_drained();
    // Top unlock level with one sample needed, lock out of reach.
    program_config(make_cfg(127, -128, 127, 1, 65535, 1));
    send_request(CMD_SAMPLE, 2031, 1'b1, 32'd5000);
    send_request(CMD_SAMPLE, 2032, 1'b1, 32'd5001);
    send_request(CMD_SAMPLE, -2048, 1'b1, 32'd5002);
    send_request(CMD_MANUAL, 0, 1'b1, 32'd6000);
    send_request(CMD_SAMPLE, -2048, 1'b1, 32'd6000);
    send_request(CMD_SAMPLE, -2048, 1'b1, 32'd6001);
  endtask

  // Full-rate traffic first, then a long hold-off on the result side while
  // requests keep coming, so that the block fills and drops ready.
  task automatic test_backpressure();
    wait_results_drained();
    program_config(make_cfg(-60, -75, 5, 2, 2, 50));
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int k = 0; k < 40; k++) begin
      send_request(CMD_SAMPLE, (k % 8 < 4) ? -900 : -1300, 1'b1, 32'(7000 + 10 * k));
    end
    // The sender pauses here until every result has come back.
    wait_results_drained();
    hold_request = 1'b1;
    while (!hold_active) @(posedge clk);
    for (int k = 0; k < 30; k++) begin
      send_request((k == 13) ? CMD_CLEAR : CMD_SAMPLE, (k % 6 < 3) ? -900 : -1300, 1'b1,
                   32'(8000 + 10 * k));
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_results_drained();
  endtask

  // Random phases, each with its own registers. Most samples land close to
  // the unlock or the lock level so that runs build up and actions fire.
  task automatic test_random_traffic();
    cfg_t c;
    cmd_t cmd;
    logic vld;
    int   pick;
    int   level;
    int   unlock_level;
    int   lock_level;
    for (int phase = 0; phase < 8; phase++) begin
      wait_results_drained();
      tx_steady = (phase == 3);
      rx_steady = (phase == 3);
      if (phase == 6) begin
        c = make_cfg($urandom_range(0, 255) - 128, $urandom_range(0, 255) - 128,
                     $urandom_range(0, 127), $urandom_range(0, 12),
                     $urandom_range(0, 12), $urandom_range(0, 65535));
      end else begin
        c = make_cfg(int'($urandom_range(0, 120)) - 100, int'($urandom_range(0, 110)) - 110,
                     $urandom_range(0, 20), $urandom_range(0, 4),
                     $urandom_range(0, 4), $urandom_range(0, 300));
      end
      program_config(c);
      unlock_level = int'($signed(c.unlock_threshold)) * 16;
      lock_level   = (int'($signed(c.lock_threshold)) - int'(c.hysteresis_db)) * 16;
      for (int k = 0; k < 100; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 90)      cmd = CMD_SAMPLE;
        else if (pick < 93) cmd = CMD_MANUAL;
        else if (pick < 97) cmd = CMD_CLEAR;
        else                cmd = CMD_RESERVED;
        vld = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 9);
        if (pick < 4)      level = unlock_level + int'($urandom_range(0, 48)) - 24;
        else if (pick < 8) level = lock_level + int'($urandom_range(0, 48)) - 24;
        else               level = int'($urandom_range(0, 4095)) - 2048;
        if (level > 2047)  level = 2047;
        if (level < -2048) level = -2048;
        // Time mostly creeps forward so cooldowns run out after a while;
        // now and then it jumps anywhere in the 32-bit range.
        if ($urandom_range(0, 49) == 0) begin
          clock_ms = $urandom();
        end else begin
          clock_ms = clock_ms + $urandom_range(0, int'(c.cooldown_ms) / 8 + 2);
        end
        send_request(cmd, level, vld, clock_ms);
        // Odd phases pause halfway until the block has gone quiet.
        if (k == 50 && phase % 2 == 1) wait_results_drained();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin : test_sequence
    rst                <= 1'b1;
    samp_if.valid      <= 1'b0;
    samp_if.cmd        <= CMD_SAMPLE;
    samp_if.rssi       <= '0;
    samp_if.rssi_valid <= 1'b0;
    samp_if.now_ms     <= '0;
    cfg_we             <= 1'b0;
    cfg_idx            <= REG_UNLOCK_THR;
    cfg_data           <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    wait_results_drained();
    if (mismatches == 0) begin
      $display("PASS rssi_lock_unlock_debouncer");
    end else begin
      $display("FAIL rssi_lock_unlock_debouncer");
    end
    $finish;
  end

endmodule
